@@ rtl/ckl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckl_pkg: shared types and codes for the compacting key list
// Status codes and the control bundle broadcast to the list cells.
// ----------------------------------------------------------------------------
package ckl_pkg;

  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;
  localparam int COUNT_W  = 4;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic             match_en;   // register compare against key
    logic             remove_en;  // shift down where a hit sits at or before the cell
    logic [KEY_W-1:0] key;
  } ckl_ctrl_t;

endpackage

@@ rtl/ckl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckl_cell: one slot of the compacting key list
// Holds one key, registers a compare hit, forwards the found chain and
// takes its right neighbor's key on a shift.
// ----------------------------------------------------------------------------
module ckl_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ckl_pkg::ckl_ctrl_t        ctrl,
  input  logic                      write,
  input  logic                      found_in,
  input  logic [ckl_pkg::KEY_W-1:0] entry_right,
  output logic [ckl_pkg::KEY_W-1:0] entry,
  output logic                      found_out,
  output logic                      first
);
  import ckl_pkg::*;

  logic hit;

  assign found_out = found_in | hit;
  assign first     = hit & ~found_in;

  // an empty slot is zero and a live key is never zero, so no valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (write) begin
      entry <= ctrl.key;
    end else if (ctrl.remove_en && found_out) begin
      entry <= entry_right;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.match_en) begin
      hit <= (entry == ctrl.key);
    end
  end

endmodule

@@ rtl/compacting_key_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_key_list: fixed-capacity key list kept compact from slot 0
// Insert appends at the tail; remove deletes the first match and closes
// the gap by shifting the later keys down one slot.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive command/key with start high; the beat is taken
//   on a rising edge where busy is low. busy rises on the next cycle and
//   stays high while the operation runs.
//   Result channel: done pulses for one cycle with status, slot and
//   entry_count. The receiver cannot stall; results are not held.
// Timing:
//   Each operation runs through accept, compare (every cell registers
//   key == entry in parallel), apply (the found chain ripples through the
//   row of cells, the cells shift or write, and the result is registered).
//   done is seen the cycle after apply, together with busy low, so a new
//   start can be taken in that same cycle, but never while an operation runs.
//   The found chain across CAPACITY cells sets the apply-cycle path.
// Reset:
//   Synchronous rst empties every slot and clears the count; no beat is
//   pending afterwards.
// Slot carries the low 3 bits of the slot index, entry_count the low
// 4 bits of the count, for capacities beyond those widths.
// ----------------------------------------------------------------------------
module compacting_key_list #(
  parameter int CAPACITY = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command,
  input  logic [ckl_pkg::KEY_W-1:0]    key,
  output logic                         done,
  output logic [ckl_pkg::STATUS_W-1:0] status,
  output logic [ckl_pkg::SLOT_W-1:0]   slot,
  output logic [ckl_pkg::COUNT_W-1:0]  entry_count
);
  import ckl_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state;
  logic             cmd;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] occupied;
  logic [CNT_W-1:0] occupied_next;

  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]    slot_next;

  ckl_ctrl_t ctrl;

  logic [KEY_W-1:0] entries   [CAPACITY];
  logic [CAPACITY:0] found;      // found[i] enters cell i
  logic [CAPACITY-1:0] first;
  logic [CAPACITY-1:0] write;
  logic [IDX_W-1:0] hit_slot;
  logic             key_ok;
  logic             is_full;

  assign busy    = (state != S_IDLE);
  assign key_ok  = (key_q != '0);
  assign is_full = (occupied >= CNT_W'(CAPACITY));

  assign ctrl.match_en  = (state == S_MATCH);
  assign ctrl.remove_en = (state == S_APPLY) && key_ok && (cmd == CMD_REMOVE);
  assign ctrl.key       = key_q;

  assign found[0] = 1'b0;

  // the row of cells; keys shift toward slot 0, the last slot takes zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] right;
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = entries[i+1];
    end

    // tail write lands on the slot just past the occupied ones
    assign write[i] = (state == S_APPLY) && key_ok && (cmd == CMD_INSERT) &&
                      !is_full && (occupied == CNT_W'(i));

    ckl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .write       (write[i]),
      .found_in    (found[i]),
      .entry_right (right),
      .entry       (entries[i]),
      .found_out   (found[i+1]),
      .first       (first[i])
    );
  end

  // at most one cell flags first, so an OR of indexes encodes it
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        hit_slot = hit_slot | IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_next   = ST_INVALID;
    slot_next     = '0;
    occupied_next = occupied;
    if (!key_ok) begin
      status_next = ST_INVALID;
    end else if (cmd == CMD_INSERT) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        status_next   = ST_INSERTED;
        slot_next     = occupied[IDX_W-1:0];
        occupied_next = occupied + CNT_W'(1);
      end
    end else if (found[CAPACITY]) begin
      status_next   = ST_REMOVED;
      slot_next     = hit_slot;
      occupied_next = occupied - CNT_W'(1);
    end else begin
      status_next = ST_NOT_FOUND;
    end
  end

  // control: sequencer, count, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occupied <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          state    <= S_IDLE;
          occupied <= occupied_next;
          done     <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  logic [IDX_W+SLOT_W-1:0]  slot_wide;
  logic [CNT_W+COUNT_W-1:0] count_wide;

  assign slot_wide  = {{SLOT_W{1'b0}}, slot_next};
  assign count_wide = {{COUNT_W{1'b0}}, occupied_next};

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd   <= command;
      key_q <= key;
    end
    if (state == S_APPLY) begin
      status      <= status_next;
      slot        <= slot_wide[SLOT_W-1:0];
      entry_count <= count_wide[COUNT_W-1:0];
    end
  end

  // checks
  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_APPLY)
    else $error("result strobe without an apply cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    occupied <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_MATCH)
    else $error("accepted beat did not enter compare");

  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_REMOVED) |-> occupied == $past(occupied) - CNT_W'(1))
    else $error("remove did not drop the count by one");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_INSERTED) |-> occupied == $past(occupied) + CNT_W'(1))
    else $error("insert did not raise the count by one");

endmodule

@@ verif/compacting_key_list_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_key_list_test: self-checking bench for the compacting key list
// A directed table covers the empty, full and zero-key corners and duplicate
// removal. A random run of inserts and removes follows, with random sender
// gaps, and every result is checked against an in-bench list model.
// ----------------------------------------------------------------------------
module compacting_key_list_test;
  import ckl_pkg::*;

  localparam int LIST_DEPTH  = 8;
  localparam int RAND_BEATS  = 1400;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat taken and no done
  localparam int DRAIN_EVERY = 250;   // sender waits for all results this often

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  entry_count;
  } op_result_t;

  // One row of the directed table. has_fixed marks rows whose result is
  // typed in; the others take the list model's answer.
  typedef struct packed {
    logic       command;
    key_t       key;
    bit         has_fixed;
    op_result_t fixed;
  } list_op_row_t;

  localparam key_t KEY_ONES = {KEY_W{1'b1}};
  localparam key_t KEY_MSB  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_ABC  = 64'h0000_0000_0061_6263;
  localparam key_t KEY_AH   = 64'h4142_4344_4546_4748;
  localparam key_t KEY_ZZ   = 64'h7a7a_0000_0000_0000;
  localparam key_t KEY_ALT  = 64'h5555_5555_5555_5555;
  localparam op_result_t NO_FIXED = '0;

  localparam int DIRECTED_ROWS = 25;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic command;
  key_t key;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [COUNT_W-1:0]  entry_count;

  // list model state
  key_t       model_keys [LIST_DEPTH];
  int         model_fill;
  op_result_t pending_results [$];
  int         fail_count;
  int         idle_cycles;

  // Directed sequence: empty list, zero keys, extreme keys, fill to capacity
  // with a duplicate, insert on a full list, remove the duplicate twice,
  // head / tail / missing removes, drain back to empty, then insert again.
  list_op_row_t directed_ops [DIRECTED_ROWS] = '{
    '{CMD_REMOVE, KEY_ONES, 1'b1, '{ST_NOT_FOUND, 3'd0, 4'd0}},
    '{CMD_INSERT, '0,       1'b1, '{ST_INVALID,   3'd0, 4'd0}},
    '{CMD_REMOVE, '0,       1'b1, '{ST_INVALID,   3'd0, 4'd0}},
    '{CMD_INSERT, KEY_ONES, 1'b1, '{ST_INSERTED,  3'd0, 4'd1}},
    '{CMD_INSERT, 64'd1,    1'b1, '{ST_INSERTED,  3'd1, 4'd2}},
    '{CMD_INSERT, KEY_ABC,  1'b0, NO_FIXED},
    '{CMD_INSERT, 64'd1,    1'b0, NO_FIXED},
    '{CMD_INSERT, KEY_MSB,  1'b0, NO_FIXED},
    '{CMD_INSERT, KEY_ZZ,   1'b0, NO_FIXED},
    '{CMD_INSERT, KEY_AH,   1'b0, NO_FIXED},
    '{CMD_INSERT, KEY_ALT,  1'b0, NO_FIXED},
    '{CMD_INSERT, 64'h77,   1'b1, '{ST_FULL,      3'd0, 4'd8}},
    '{CMD_INSERT, '0,       1'b1, '{ST_INVALID,   3'd0, 4'd8}},
    '{CMD_REMOVE, 64'd1,    1'b0, NO_FIXED},
    '{CMD_REMOVE, 64'd1,    1'b0, NO_FIXED},
    '{CMD_REMOVE, 64'd1,    1'b0, NO_FIXED},
    '{CMD_REMOVE, KEY_ONES, 1'b0, NO_FIXED},
    '{CMD_REMOVE, KEY_ALT,  1'b0, NO_FIXED},
    '{CMD_REMOVE, 64'hdead, 1'b0, NO_FIXED},
    '{CMD_REMOVE, KEY_MSB,  1'b0, NO_FIXED},
    '{CMD_REMOVE, KEY_AH,   1'b0, NO_FIXED},
    '{CMD_REMOVE, KEY_ZZ,   1'b0, NO_FIXED},
    '{CMD_REMOVE, KEY_ABC,  1'b0, NO_FIXED},
    '{CMD_REMOVE, KEY_ABC,  1'b1, '{ST_NOT_FOUND, 3'd0, 4'd0}},
    '{CMD_INSERT, KEY_MSB,  1'b1, '{ST_INSERTED,  3'd0, 4'd1}}
  };

  compacting_key_list #(
    .CAPACITY(LIST_DEPTH)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .key         (key),
    .done        (done),
    .status      (status),
    .slot        (slot),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one operation to the list model and return what the block owes.
  task automatic apply_list_op(input logic cmd, input key_t k, output op_result_t res);
    int hit;
    hit = -1;
    res = '0;
    if (k == '0) begin
      res.status = ST_INVALID;
    end else if (cmd == CMD_INSERT) begin
      if (model_fill >= LIST_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        model_keys[model_fill] = k;
        res.status = ST_INSERTED;
        res.slot   = model_fill[SLOT_W-1:0];
        model_fill++;
      end
    end else begin
      // first match only; duplicates further up stay put
      for (int i = 0; i < model_fill; i++) begin
        if (hit < 0 && model_keys[i] == k) hit = i;
      end
      if (hit < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        for (int i = hit; i < LIST_DEPTH - 1; i++) model_keys[i] = model_keys[i + 1];
        model_keys[LIST_DEPTH - 1] = '0;
        model_fill--;
        res.status = ST_REMOVED;
        res.slot   = hit[SLOT_W-1:0];
      end
    end
    res.entry_count = model_fill[COUNT_W-1:0];
  endtask

  // Present one beat, hold it until taken, then idle for the requested gap
  // with junk on the command lines. Returns on a clock edge with no pending
  // assignment to start in that step.
  task automatic send_beat(input logic cmd, input key_t k, input bit has_fixed,
                           input op_result_t fixed, input int gap);
    op_result_t owed;
    start   <= 1'b1;
    command <= cmd;
    key     <= k;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    apply_list_op(cmd, k, owed);
    pending_results.push_back(has_fixed ? fixed : owed);
    if (gap > 0) begin
      start   <= 1'b0;
      command <= 1'($urandom_range(0, 1));
      key     <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Remove keys mostly come from the live list so the shift path is hit.
  function automatic key_t pick_key(logic cmd);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (cmd == CMD_REMOVE && model_fill > 0 && r < 75)
      return model_keys[$urandom_range(0, model_fill - 1)];
    if (r < 45) return key_t'($urandom_range(1, 6));  // small pool: duplicates
    return {$urandom, $urandom};
  endfunction

  // Result checker: done is sampled at the edge that ends its cycle.
  always @(posedge clk) begin : check_results
    op_result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d slot %0d entry_count %0d",
               status, slot, entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          fail_count++;
        end
        if (slot !== want.slot) begin
          $error("slot: expected %0d, actual %0d", want.slot, slot);
          fail_count++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any taken beat or any done counts as progress.
  always @(posedge clk) begin : watchdog
    if (rst || (start && busy === 1'b0) || done === 1'b1) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int   insert_pct;
    bit   burst;
    logic cmd;
    key_t k;
    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_INSERT;
    key         = '0;
    fail_count  = 0;
    idle_cycles = 0;
    model_fill  = 0;
    for (int i = 0; i < LIST_DEPTH; i++) model_keys[i] = '0;
    insert_pct  = 50;
    burst       = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_beat(directed_ops[i].command, directed_ops[i].key, directed_ops[i].has_fixed,
                directed_ops[i].fixed, pick_gap(1'b0));
    end

    // random run; the insert mix changes every 100 beats so the list
    // swings between empty, half full and full
    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 25;
          1: insert_pct = 55;
          default: insert_pct = 80;
        endcase
        burst = ($urandom_range(0, 3) == 0);
      end
      cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
      k   = pick_key(cmd);
      send_beat(cmd, k, 1'b0, NO_FIXED, pick_gap(burst));
      if (n % DRAIN_EVERY == DRAIN_EVERY - 1) begin
        // sender holds off until the block has answered everything
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);  // catch any stray done

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
